FILE: rtl/lipnc_pkg.sv
// Shared types and constants for the IP-to-name LRU cache.
package lipnc_pkg;

  localparam int CMD_W     = 2;
  localparam int IP_W      = 32;
  localparam int DOMAIN_W  = 64;
  localparam int TIME_W    = 63;
  localparam int HITS_W    = 32;
  localparam int ECOUNT_W  = 7;

  localparam int S_DATA_W  = 160;
  localparam int M_DATA_W  = 112;

  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam int OUT_FOUND_LSB   = 0;
  localparam int OUT_DOMAIN_LSB  = 1;
  localparam int OUT_HITS_LSB    = OUT_DOMAIN_LSB + DOMAIN_W;
  localparam int OUT_EVICTED_LSB = OUT_HITS_LSB + HITS_W;
  localparam int OUT_COUNT_LSB   = OUT_EVICTED_LSB + 1;

  typedef struct packed {
    logic                valid;
    logic [IP_W-1:0]     ip;
    logic [DOMAIN_W-1:0] domain;
    logic [TIME_W-1:0]   last_use;
    logic [HITS_W-1:0]   hits;
  } entry_t;

endpackage

FILE: rtl/lru_ip_to_name_cache.sv
// Top level of the fully associative IP-to-name LRU cache.
// Store with a nonzero domain and lookup: one scan over the entry memory, one
// read per cycle, then at most one write back (none on a lookup miss), then the
// result; a new item is taken only once the result of the previous one is issued.
// Clear: a sweep over all entries, then the result. Other items: the result only.
// Reset runs the same sweep with s_tready low.
module lru_ip_to_name_cache #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // ip, domain_value, time_now, zero pad
  input  logic [lipnc_pkg::S_DATA_W-1:0] s_tdata,
  // command
  input  logic [lipnc_pkg::CMD_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // found, result_domain, hit_count, evicted, entry_count, zero pad
  output logic [lipnc_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                       state;
  logic [lipnc_pkg::CMD_W-1:0]      cmd_q;
  logic [lipnc_pkg::IP_W-1:0]       key_q;
  logic [lipnc_pkg::DOMAIN_W-1:0]   dom_q;
  logic [lipnc_pkg::TIME_W-1:0]     now_q;
  logic [AW-1:0]                    scan_addr;
  logic                             issue_done;
  logic                             chk_valid;
  logic [AW-1:0]                    chk_idx;
  logic                             match_hit;
  logic [AW-1:0]                    match_idx;
  lipnc_pkg::entry_t                match_entry;
  logic                             free_hit;
  logic [AW-1:0]                    free_idx;
  logic                             old_hit;
  logic [AW-1:0]                    old_idx;
  logic [lipnc_pkg::TIME_W-1:0]     old_time;
  logic                             res_found;
  logic [lipnc_pkg::DOMAIN_W-1:0]   res_dom;
  logic [lipnc_pkg::HITS_W-1:0]     res_hits;
  logic                             res_evicted;
  logic [CW-1:0]                    count;
  logic                             clr_emit;

  logic                             res_found_next;
  logic [lipnc_pkg::DOMAIN_W-1:0]   res_dom_next;
  logic [lipnc_pkg::HITS_W-1:0]     res_hits_next;
  logic                             res_evicted_next;
  logic [CW-1:0]                    count_next;
  logic [lipnc_pkg::HITS_W-1:0]     hits_inc;

  lipnc_pkg::entry_t                mem [ENTRIES];
  lipnc_pkg::entry_t                rd_data;
  lipnc_pkg::entry_t                wr_data;
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;

  logic [CW+lipnc_pkg::ECOUNT_W-1:0] count_ext;

  logic s_fire;

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign count_ext = {{lipnc_pkg::ECOUNT_W{1'b0}}, count};
  assign hits_inc  = (match_entry.hits == lipnc_pkg::HITS_MAX) ? match_entry.hits
                                                              : match_entry.hits + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[scan_addr];
  end

  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = scan_addr;
    wr_data          = '0;
    res_found_next   = 1'b0;
    res_dom_next     = '0;
    res_hits_next    = '0;
    res_evicted_next = 1'b0;
    count_next       = count;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_WRITE: begin
        if (cmd_q == lipnc_pkg::CMD_LOOKUP) begin
          if (match_hit) begin
            wr_en            = 1'b1;
            wr_addr          = match_idx;
            wr_data          = match_entry;
            wr_data.last_use = now_q;
            res_found_next   = 1'b1;
            res_dom_next     = match_entry.domain;
            res_hits_next    = match_entry.hits;
          end
        end else begin
          wr_en            = 1'b1;
          wr_data.valid    = 1'b1;
          wr_data.ip       = key_q;
          wr_data.domain   = dom_q;
          wr_data.last_use = now_q;
          if (match_hit) begin
            wr_addr        = match_idx;
            wr_data.hits   = hits_inc;
            res_found_next = 1'b1;
            res_dom_next   = dom_q;
            res_hits_next  = hits_inc;
          end else begin
            wr_data.hits  = lipnc_pkg::HITS_W'(1);
            res_hits_next = lipnc_pkg::HITS_W'(1);
            if (count == FULL) begin
              wr_addr          = old_idx;
              res_evicted_next = 1'b1;
            end else begin
              wr_addr    = free_idx;
              count_next = count + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      scan_addr  <= '0;
      issue_done <= 1'b0;
      chk_valid  <= 1'b0;
      count      <= '0;
      clr_emit   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == LAST) begin
            scan_addr <= '0;
            count     <= '0;
            state     <= clr_emit ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            cmd_q       <= s_tuser;
            key_q       <= s_tdata[lipnc_pkg::IP_W-1:0];
            dom_q       <= s_tdata[lipnc_pkg::IP_W +: lipnc_pkg::DOMAIN_W];
            now_q       <= s_tdata[lipnc_pkg::IP_W+lipnc_pkg::DOMAIN_W +: lipnc_pkg::TIME_W];
            res_found   <= 1'b0;
            res_dom     <= '0;
            res_hits    <= '0;
            res_evicted <= 1'b0;
            scan_addr   <= '0;
            issue_done  <= 1'b0;
            chk_valid   <= 1'b0;
            match_hit   <= 1'b0;
            free_hit    <= 1'b0;
            old_hit     <= 1'b0;
            clr_emit    <= 1'b0;
            case (s_tuser)
              lipnc_pkg::CMD_STORE: begin
                state <= (s_tdata[lipnc_pkg::IP_W +: lipnc_pkg::DOMAIN_W] != '0) ? ST_SCAN
                                                                                 : ST_FINISH;
              end
              lipnc_pkg::CMD_LOOKUP: state <= ST_SCAN;
              lipnc_pkg::CMD_CLEAR: begin
                clr_emit <= 1'b1;
                state    <= ST_CLEAR;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_SCAN: begin
          chk_valid <= !issue_done;
          chk_idx   <= scan_addr;
          if (!issue_done) begin
            if (scan_addr == LAST) begin
              issue_done <= 1'b1;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (chk_valid) begin
            if (rd_data.valid && rd_data.ip == key_q && !match_hit) begin
              match_hit   <= 1'b1;
              match_idx   <= chk_idx;
              match_entry <= rd_data;
            end
            if (!rd_data.valid && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= chk_idx;
            end
            if (rd_data.valid && (!old_hit || rd_data.last_use < old_time)) begin
              old_hit  <= 1'b1;
              old_idx  <= chk_idx;
              old_time <= rd_data.last_use;
            end
            if (chk_idx == LAST) begin
              chk_valid <= 1'b0;
              scan_addr <= '0;
              state     <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          res_found   <= res_found_next;
          res_dom     <= res_dom_next;
          res_hits    <= res_hits_next;
          res_evicted <= res_evicted_next;
          count       <= count_next;
          state       <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(lipnc_pkg::M_DATA_W - lipnc_pkg::OUT_COUNT_LSB
                           - lipnc_pkg::ECOUNT_W){1'b0}},
                         count_ext[lipnc_pkg::ECOUNT_W-1:0],
                         res_evicted, res_hits, res_dom, res_found};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lipnc_checker.sv
// Port-level checker for the IP-to-name LRU cache, with its bind.
module lipnc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [lipnc_pkg::M_DATA_W-1:0] m_tdata
);

  logic                            found;
  logic                            evicted;
  logic [lipnc_pkg::DOMAIN_W-1:0]  rdom;
  logic [lipnc_pkg::HITS_W-1:0]    hits;

  assign found   = m_tdata[lipnc_pkg::OUT_FOUND_LSB];
  assign evicted = m_tdata[lipnc_pkg::OUT_EVICTED_LSB];
  assign rdom    = m_tdata[lipnc_pkg::OUT_DOMAIN_LSB +: lipnc_pkg::DOMAIN_W];
  assign hits    = m_tdata[lipnc_pkg::OUT_HITS_LSB +: lipnc_pkg::HITS_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_found_not_evicted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(found && evicted))
    else $error("item both found and evicted");

  a_miss_zero_domain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !found |-> rdom == '0)
    else $error("domain nonzero without a hit");

  a_evict_new_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && evicted |-> hits == lipnc_pkg::HITS_W'(1))
    else $error("evicting store did not report a fresh entry");

  a_found_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && found |-> hits != '0)
    else $error("hit entry reports zero count");

endmodule

bind lru_ip_to_name_cache lipnc_checker u_lipnc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/sv/name_cache_checker.sv
// Reply checker for the IP-to-name LRU cache: predicts each reply and compares it.
module name_cache_checker #(
  parameter int ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // ip, domain_value, time_now, zero pad
  input  logic [lipnc_pkg::S_DATA_W-1:0] s_tdata,
  // command
  input  logic [lipnc_pkg::CMD_W-1:0]    s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // found, result_domain, hit_count, evicted, entry_count, zero pad
  input  logic [lipnc_pkg::M_DATA_W-1:0] m_tdata,
  output int                             outstanding,
  output int                             fail_count
);

  typedef struct packed {
    logic                           found;
    logic [lipnc_pkg::DOMAIN_W-1:0] domain;
    logic [lipnc_pkg::HITS_W-1:0]   hits;
    logic                           evicted;
    logic [lipnc_pkg::ECOUNT_W-1:0] count;
  } cache_reply_t;

  logic                           line_valid  [ENTRIES];
  logic [lipnc_pkg::IP_W-1:0]     line_ip     [ENTRIES];
  logic [lipnc_pkg::DOMAIN_W-1:0] line_domain [ENTRIES];
  logic [lipnc_pkg::TIME_W-1:0]   line_stamp  [ENTRIES];
  logic [lipnc_pkg::HITS_W-1:0]   line_hits   [ENTRIES];
  int                             lines_live;

  cache_reply_t pending_replies[$];
  int           mismatches;

  task automatic predict_reply(input logic [lipnc_pkg::CMD_W-1:0] cmd,
                               input logic [lipnc_pkg::IP_W-1:0] ip,
                               input logic [lipnc_pkg::DOMAIN_W-1:0] dom,
                               input logic [lipnc_pkg::TIME_W-1:0] stamp,
                               output cache_reply_t r);
    int i;
    int hit;
    int oldest;
    int spare;
    r      = '0;
    hit    = -1;
    oldest = -1;
    spare  = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && line_valid[i] && line_ip[i] == ip) hit = i;
    end
    case (cmd)
      lipnc_pkg::CMD_STORE: begin
        if (dom != '0) begin
          if (hit >= 0) begin
            line_domain[hit] = dom;
            line_stamp[hit]  = stamp;
            if (line_hits[hit] != lipnc_pkg::HITS_MAX) line_hits[hit] = line_hits[hit] + 1'b1;
            r.found  = 1'b1;
            r.domain = dom;
            r.hits   = line_hits[hit];
          end else begin
            if (lines_live >= ENTRIES) begin
              for (i = 0; i < ENTRIES; i++) begin
                if (line_valid[i] && (oldest < 0 || line_stamp[i] < line_stamp[oldest]))
                  oldest = i;
              end
              if (oldest >= 0) begin
                line_valid[oldest] = 1'b0;
                if (lines_live > 0) lines_live--;
                r.evicted = 1'b1;
              end
            end
            for (i = 0; i < ENTRIES; i++) begin
              if (spare < 0 && !line_valid[i]) spare = i;
            end
            if (spare >= 0) begin
              line_valid[spare]  = 1'b1;
              line_ip[spare]     = ip;
              line_domain[spare] = dom;
              line_stamp[spare]  = stamp;
              line_hits[spare]   = lipnc_pkg::HITS_W'(1);
              lines_live++;
              r.hits = lipnc_pkg::HITS_W'(1);
            end
          end
        end
      end
      lipnc_pkg::CMD_LOOKUP: begin
        if (hit >= 0) begin
          line_stamp[hit] = stamp;
          r.found  = 1'b1;
          r.domain = line_domain[hit];
          r.hits   = line_hits[hit];
        end
      end
      lipnc_pkg::CMD_CLEAR: begin
        for (i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
        lines_live = 0;
      end
      default: begin
      end
    endcase
    r.count = lipnc_pkg::ECOUNT_W'(lines_live);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cache_reply_t want;
    cache_reply_t got;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
      lines_live = 0;
      mismatches = 0;
      pending_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.found   = m_tdata[lipnc_pkg::OUT_FOUND_LSB];
        got.domain  = m_tdata[lipnc_pkg::OUT_DOMAIN_LSB +: lipnc_pkg::DOMAIN_W];
        got.hits    = m_tdata[lipnc_pkg::OUT_HITS_LSB +: lipnc_pkg::HITS_W];
        got.evicted = m_tdata[lipnc_pkg::OUT_EVICTED_LSB];
        got.count   = m_tdata[lipnc_pkg::OUT_COUNT_LSB +: lipnc_pkg::ECOUNT_W];
        if (pending_replies.size() == 0) begin
          $error("reply 0x%0h arrived with no item pending", m_tdata);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          check_field("found", 64'(want.found), 64'(got.found));
          check_field("result_domain", want.domain, got.domain);
          check_field("hit_count", 64'(want.hits), 64'(got.hits));
          check_field("evicted", 64'(want.evicted), 64'(got.evicted));
          check_field("entry_count", 64'(want.count), 64'(got.count));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_reply(s_tuser, s_tdata[0 +: lipnc_pkg::IP_W],
                      s_tdata[lipnc_pkg::IP_W +: lipnc_pkg::DOMAIN_W],
                      s_tdata[lipnc_pkg::IP_W+lipnc_pkg::DOMAIN_W +: lipnc_pkg::TIME_W],
                      want);
        pending_replies.push_back(want);
      end
    end
    outstanding <= pending_replies.size();
    fail_count  <= mismatches;
  end

endmodule

FILE: tb/sv/tb_lru_ip_to_name_cache.sv
// Testbench top for the IP-to-name LRU cache: clock, reset, item stimulus and verdict.
module tb_lru_ip_to_name_cache;

  localparam int ENTRIES      = 64;
  localparam int RANDOM_ITEMS = 450;
  localparam int IP_POOL      = 96;
  localparam int PAD_W        = lipnc_pkg::S_DATA_W - lipnc_pkg::IP_W - lipnc_pkg::DOMAIN_W
                                - lipnc_pkg::TIME_W;

  localparam logic [lipnc_pkg::CMD_W-1:0]  CMD_RESERVED = 2'd3;
  localparam logic [lipnc_pkg::TIME_W-1:0] TIME_TOP     = '1;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [lipnc_pkg::S_DATA_W-1:0] s_tdata;
  logic [lipnc_pkg::CMD_W-1:0]    s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [lipnc_pkg::M_DATA_W-1:0] m_tdata;
  int                             outstanding;
  int                             fail_count;

  int                             idle_pct;
  int                             stall_pct;
  logic [lipnc_pkg::IP_W-1:0]     ip_pool [IP_POOL];
  logic [lipnc_pkg::TIME_W-1:0]   stamp_clock;

  lru_ip_to_name_cache #(.ENTRIES(ENTRIES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  name_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(input logic [lipnc_pkg::CMD_W-1:0] cmd,
                           input logic [lipnc_pkg::IP_W-1:0] ip,
                           input logic [lipnc_pkg::DOMAIN_W-1:0] dom,
                           input logic [lipnc_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(0, 7) == 0) gap += $urandom_range(1, 100);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, stamp, dom, ip};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pick_domain(output logic [lipnc_pkg::DOMAIN_W-1:0] dom);
    int r;
    r = $urandom_range(0, 31);
    if (r < 2) dom = '0;
    else if (r == 2) dom = '1;
    else dom = {$urandom, $urandom};
  endtask

  task automatic pick_stamp(output logic [lipnc_pkg::TIME_W-1:0] stamp);
    int r;
    logic [63:0] wide;
    r = $urandom_range(0, 31);
    wide = {$urandom, $urandom};
    if (r == 0) begin
      stamp = wide[lipnc_pkg::TIME_W-1:0];
    end else if (r == 1) begin
      stamp = TIME_TOP;
    end else begin
      stamp_clock = stamp_clock + lipnc_pkg::TIME_W'($urandom_range(0, 3));
      stamp = stamp_clock;
    end
  endtask

  initial begin
    int counted;
    int phase;
    int kind;
    int run;
    logic [lipnc_pkg::CMD_W-1:0]    cmd;
    logic [lipnc_pkg::IP_W-1:0]     ip;
    logic [lipnc_pkg::DOMAIN_W-1:0] dom;
    logic [lipnc_pkg::TIME_W-1:0]   stamp;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= lipnc_pkg::CMD_STORE;
    idle_pct  = 0;
    stall_pct = 0;
    stamp_clock = lipnc_pkg::TIME_W'(100);
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < IP_POOL; i++) ip_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_item(lipnc_pkg::CMD_LOOKUP, 32'h0, 64'h0, 63'd0);
    send_item(lipnc_pkg::CMD_STORE, 32'h0, 64'h0, 63'd1);
    send_item(lipnc_pkg::CMD_STORE, 32'h0, '1, 63'd0);
    send_item(lipnc_pkg::CMD_STORE, '1, 64'h1, TIME_TOP);
    send_item(lipnc_pkg::CMD_LOOKUP, 32'h0, 64'h0, 63'd5);
    send_item(lipnc_pkg::CMD_STORE, 32'h0, 64'h5A5A_5A5A_5A5A_5A5A, 63'd6);
    send_item(lipnc_pkg::CMD_STORE, 32'h0, 64'hA5A5_A5A5_A5A5_A5A5, 63'd7);
    send_item(lipnc_pkg::CMD_LOOKUP, '1, '1, '1);
    send_item(lipnc_pkg::CMD_STORE, '1, 64'h0, 63'd8);
    send_item(CMD_RESERVED, '1, '1, '1);
    send_item(lipnc_pkg::CMD_LOOKUP, 32'h1234_5678, 64'h0, 63'd9);
    send_item(lipnc_pkg::CMD_STORE, 32'h8000_0000, 64'h8000_0000_0000_0000,
              63'h4000_0000_0000_0000);
    send_item(lipnc_pkg::CMD_STORE, 32'h0000_0001, 64'h0000_0000_0000_0001, 63'd10);
    send_item(lipnc_pkg::CMD_CLEAR, '1, '1, '1);
    send_item(lipnc_pkg::CMD_LOOKUP, 32'h0, 64'h0, 63'd11);
    send_item(lipnc_pkg::CMD_LOOKUP, '1, 64'h0, 63'd12);
    send_item(lipnc_pkg::CMD_STORE, '1, 64'hFFFF_FFFF_0000_0000, 63'd13);
    send_item(CMD_RESERVED, 32'h0, 64'h0, 63'd0);
    send_item(lipnc_pkg::CMD_CLEAR, 32'h0, 64'h0, 63'd0);
    send_item(lipnc_pkg::CMD_CLEAR, 32'h0, 64'h0, 63'd0);
    send_item(lipnc_pkg::CMD_STORE, 32'hC0A8_0001, 64'h0123_4567_89AB_CDEF, 63'd20);
    send_item(lipnc_pkg::CMD_LOOKUP, 32'hC0A8_0001, 64'h0, 63'd21);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = counted * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 37;
          stall_pct = 37;
        end
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        run = $urandom_range(6, 24);
        repeat (run) begin
          pick_domain(dom);
          pick_stamp(stamp);
          send_item(lipnc_pkg::CMD_STORE, ip_pool[$urandom_range(0, IP_POOL-1)], dom, stamp);
          if (dom != '0) counted++;
        end
      end else if (kind < 80) begin
        run = $urandom_range(4, 16);
        repeat (run) begin
          ip = ($urandom_range(0, 7) == 0) ? $urandom : ip_pool[$urandom_range(0, IP_POOL-1)];
          pick_stamp(stamp);
          send_item(lipnc_pkg::CMD_LOOKUP, ip, {$urandom, $urandom}, stamp);
          counted++;
        end
      end else if (kind < 97) begin
        run = $urandom_range(2, 6);
        repeat (run) begin
          cmd = lipnc_pkg::CMD_W'($urandom_range(0, 3));
          ip = $urandom_range(0, 1) ? $urandom : ip_pool[$urandom_range(0, IP_POOL-1)];
          dom = $urandom_range(0, 3) == 0 ? '0 : {$urandom, $urandom};
          pick_stamp(stamp);
          send_item(cmd, ip, dom, stamp);
          if (!(cmd == CMD_RESERVED || (cmd == lipnc_pkg::CMD_STORE && dom == '0))) counted++;
        end
      end else begin
        pick_stamp(stamp);
        send_item(lipnc_pkg::CMD_CLEAR, $urandom, {$urandom, $urandom}, stamp);
        counted++;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
